[src/uvg_pkg.sv]
// ----------------------------------------------------------------------------
// uvg_pkg
// shared constants, codes and types of the upwind volume gradient unit
// ----------------------------------------------------------------------------
`default_nettype none

package uvg_pkg;

   // volume limits and sample format
   localparam int MAX_WIDTH   = 64;
   localparam int MAX_HEIGHT  = 64;
   localparam int MAX_DEPTH   = 1024;
   localparam int SAMPLE_BITS = 16;
   localparam int GRAD_BITS   = SAMPLE_BITS + 1;

   // plane store: two planes of the largest volume
   localparam int STORE_DEPTH = 2 * MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

   // coordinate counters
   localparam int X_BITS = $clog2(MAX_WIDTH);
   localparam int Y_BITS = $clog2(MAX_HEIGHT);
   localparam int Z_BITS = $clog2(MAX_DEPTH);

   // register fields
   localparam int WIDTH_REG_BITS  = 7;
   localparam int HEIGHT_REG_BITS = 7;
   localparam int DEPTH_REG_BITS  = 11;
   localparam int CSR_ADDR_BITS   = 2;
   localparam int CSR_DATA_BITS   = 11;

   localparam logic [WIDTH_REG_BITS-1:0]  RESET_VOL_WIDTH  = WIDTH_REG_BITS'(64);
   localparam logic [HEIGHT_REG_BITS-1:0] RESET_VOL_HEIGHT = HEIGHT_REG_BITS'(64);
   localparam logic [DEPTH_REG_BITS-1:0]  RESET_VOL_DEPTH  = DEPTH_REG_BITS'(64);

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_VOL_WIDTH,
      REG_VOL_HEIGHT,
      REG_VOL_DEPTH,
      REG_WIND_DIRECTION
   } csr_index_type;

   typedef enum logic {
      CMD_PUSH  = 1'b0,
      CMD_FLUSH = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      AXIS_ZERO,
      AXIS_BACK,
      AXIS_FWD,
      AXIS_UPWIND
   } axis_mode_type;

   typedef struct packed {
      logic [WIDTH_REG_BITS-1:0]  vol_width;
      logic [HEIGHT_REG_BITS-1:0] vol_height;
      logic [DEPTH_REG_BITS-1:0]  vol_depth;
      logic                       wind_direction;
   } cfg_type;

   typedef struct packed {
      logic                          wr_en;
      logic [ADDR_BITS-1:0]          wr_addr;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          emit;
      logic [ADDR_BITS-1:0]          ctr_addr;
      logic [ADDR_BITS-1:0]          zm_addr;
      axis_mode_type                 mode_x;
      axis_mode_type                 mode_y;
      axis_mode_type                 mode_z;
      logic                          last;
   } queue_entry_type;

   typedef struct packed {
      logic                 full;
      logic                 empty;
      logic [QPTR_BITS:0]   count;
   } queue_status_type;

endpackage

`default_nettype wire

[src/uvg_ram.sv]
// ----------------------------------------------------------------------------
// uvg_ram
// plane store copy: one write port, two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module uvg_ram
   import uvg_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [ADDR_BITS-1:0]   wr_addr,
   input  wire logic [SAMPLE_BITS-1:0] wr_data,
   input  wire logic                   rd_en,
   input  wire logic [ADDR_BITS-1:0]   rd_addr_a,
   input  wire logic [ADDR_BITS-1:0]   rd_addr_b,
   output logic [SAMPLE_BITS-1:0]      rd_data_a,
   output logic [SAMPLE_BITS-1:0]      rd_data_b
);

   logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
   logic [SAMPLE_BITS-1:0] rd_a_ff;
   logic [SAMPLE_BITS-1:0] rd_b_ff;

   // read returns the old word on a same-cycle write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

[src/uvg_front.sv]
// ----------------------------------------------------------------------------
// uvg_front
// register file, raster counters and per-transaction classification
// ----------------------------------------------------------------------------
`default_nettype none

module uvg_front
   import uvg_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [CSR_ADDR_BITS-1:0]      csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0]      csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_cmd,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample,
   input  wire logic                          queue_full,
   output logic                               enq_valid,
   output queue_entry_type                    enq_entry,
   output cfg_type                            cfg,
   output logic                               in_done
);

   cfg_type              cfg_ff, cfg_in;
   logic [X_BITS-1:0]    in_x_ff, in_x_in, out_x_ff, out_x_in;
   logic [Y_BITS-1:0]    in_y_ff, in_y_in, out_y_ff, out_y_in;
   logic [Z_BITS-1:0]    in_z_ff, in_z_in, out_z_ff, out_z_in;
   logic [ADDR_BITS-1:0] wr_addr_ff, wr_addr_in;
   logic [ADDR_BITS-1:0] ctr_addr_ff, ctr_addr_in;
   logic [ADDR_BITS-1:0] zm_addr_ff, zm_addr_in;
   logic                 in_done_ff, in_done_in;

   logic [X_BITS-1:0] x_end;
   logic [Y_BITS-1:0] y_end;
   logic [Z_BITS-1:0] z_end;
   logic in_x_wrap, in_y_wrap, in_z_wrap, in_final;
   logic out_x_wrap, out_y_wrap, out_z_wrap, out_final;
   logic csr_fire, accept, push_take, flush_take, emit;

   function automatic axis_mode_type axis_mode(input logic size_one, input logic at_first,
                                               input logic at_last);
      if (size_one) return AXIS_ZERO;
      if (at_last) return AXIS_BACK;
      if (at_first) return AXIS_FWD;
      return AXIS_UPWIND;
   endfunction

   function automatic logic [WIDTH_REG_BITS-1:0] clamp_dim(input logic [WIDTH_REG_BITS-1:0] v,
                                                          input logic [WIDTH_REG_BITS-1:0] hi);
      if (v == '0) return WIDTH_REG_BITS'(1);
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [DEPTH_REG_BITS-1:0] clamp_depth(input logic [DEPTH_REG_BITS-1:0] v);
      if (v == '0) return DEPTH_REG_BITS'(1);
      if (v > DEPTH_REG_BITS'(MAX_DEPTH)) return DEPTH_REG_BITS'(MAX_DEPTH);
      return v;
   endfunction

   assign csr_ready = 1'b1;
   assign req_ready = !queue_full;
   assign cfg       = cfg_ff;
   assign in_done   = in_done_ff;

   always_comb begin
      x_end = X_BITS'(cfg_ff.vol_width - WIDTH_REG_BITS'(1));
      y_end = Y_BITS'(cfg_ff.vol_height - HEIGHT_REG_BITS'(1));
      z_end = Z_BITS'(cfg_ff.vol_depth - DEPTH_REG_BITS'(1));

      in_x_wrap  = (in_x_ff == x_end);
      in_y_wrap  = (in_y_ff == y_end);
      in_z_wrap  = (in_z_ff == z_end);
      in_final   = in_x_wrap && in_y_wrap && in_z_wrap;
      out_x_wrap = (out_x_ff == x_end);
      out_y_wrap = (out_y_ff == y_end);
      out_z_wrap = (out_z_ff == z_end);
      out_final  = out_x_wrap && out_y_wrap && out_z_wrap;

      csr_fire   = csr_valid && csr_ready;
      accept     = req_valid && req_ready;
      // push past the end of the volume and early flush do nothing
      push_take  = (req_cmd == CMD_PUSH) && !in_done_ff;
      flush_take = (req_cmd == CMD_FLUSH) && in_done_ff;
      // a push from the second plane on completes the voxel one plane back
      emit       = (push_take && (in_z_ff != '0)) || flush_take;

      enq_valid          = accept && (push_take || flush_take);
      enq_entry.wr_en    = push_take;
      enq_entry.wr_addr  = wr_addr_ff;
      enq_entry.sample   = push_take ? req_sample : '0;
      enq_entry.emit     = emit;
      enq_entry.ctr_addr = ctr_addr_ff;
      enq_entry.zm_addr  = zm_addr_ff;
      enq_entry.mode_x   = axis_mode(cfg_ff.vol_width == WIDTH_REG_BITS'(1),
                                     out_x_ff == '0, out_x_wrap);
      enq_entry.mode_y   = axis_mode(cfg_ff.vol_height == HEIGHT_REG_BITS'(1),
                                     out_y_ff == '0, out_y_wrap);
      enq_entry.mode_z   = axis_mode(cfg_ff.vol_depth == DEPTH_REG_BITS'(1),
                                     out_z_ff == '0, out_z_wrap);
      enq_entry.last     = out_final;

      cfg_in      = cfg_ff;
      in_x_in     = in_x_ff;
      in_y_in     = in_y_ff;
      in_z_in     = in_z_ff;
      out_x_in    = out_x_ff;
      out_y_in    = out_y_ff;
      out_z_in    = out_z_ff;
      wr_addr_in  = wr_addr_ff;
      ctr_addr_in = ctr_addr_ff;
      zm_addr_in  = zm_addr_ff;
      in_done_in  = in_done_ff;

      if (csr_fire) begin
         case (csr_index_type'(csr_addr))
            REG_VOL_WIDTH: begin
               cfg_in.vol_width = clamp_dim(csr_wdata[WIDTH_REG_BITS-1:0],
                                            WIDTH_REG_BITS'(MAX_WIDTH));
            end
            REG_VOL_HEIGHT: begin
               cfg_in.vol_height = clamp_dim(csr_wdata[HEIGHT_REG_BITS-1:0],
                                             HEIGHT_REG_BITS'(MAX_HEIGHT));
            end
            REG_VOL_DEPTH: begin
               cfg_in.vol_depth = clamp_depth(csr_wdata[DEPTH_REG_BITS-1:0]);
            end
            REG_WIND_DIRECTION: begin
               cfg_in.wind_direction = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
         // any register write drops the partial volume
         in_x_in     = '0;
         in_y_in     = '0;
         in_z_in     = '0;
         out_x_in    = '0;
         out_y_in    = '0;
         out_z_in    = '0;
         wr_addr_in  = '0;
         ctr_addr_in = '0;
         zm_addr_in  = '0;
         in_done_in  = 1'b0;
      end else if (enq_valid) begin
         if (push_take) begin
            in_x_in    = in_x_wrap ? '0 : in_x_ff + X_BITS'(1);
            if (in_x_wrap) begin
               in_y_in = in_y_wrap ? '0 : in_y_ff + Y_BITS'(1);
            end
            if (in_x_wrap && in_y_wrap) begin
               in_z_in = in_z_wrap ? '0 : in_z_ff + Z_BITS'(1);
            end
            wr_addr_in = wr_addr_ff + ADDR_BITS'(1);
            if (in_final) begin
               in_done_in = 1'b1;
            end
         end
         if (emit) begin
            out_x_in    = out_x_wrap ? '0 : out_x_ff + X_BITS'(1);
            if (out_x_wrap) begin
               out_y_in = out_y_wrap ? '0 : out_y_ff + Y_BITS'(1);
            end
            if (out_x_wrap && out_y_wrap) begin
               out_z_in = out_z_wrap ? '0 : out_z_ff + Z_BITS'(1);
            end
            ctr_addr_in = ctr_addr_ff + ADDR_BITS'(1);
            // z back neighbor address starts at zero with the second plane
            if (out_z_ff != '0) begin
               zm_addr_in = zm_addr_ff + ADDR_BITS'(1);
            end
            if (out_final) begin
               in_x_in     = '0;
               in_y_in     = '0;
               in_z_in     = '0;
               out_x_in    = '0;
               out_y_in    = '0;
               out_z_in    = '0;
               wr_addr_in  = '0;
               ctr_addr_in = '0;
               zm_addr_in  = '0;
               in_done_in  = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vol_width      <= RESET_VOL_WIDTH;
         cfg_ff.vol_height     <= RESET_VOL_HEIGHT;
         cfg_ff.vol_depth      <= RESET_VOL_DEPTH;
         cfg_ff.wind_direction <= 1'b0;
         in_x_ff               <= '0;
         in_y_ff               <= '0;
         in_z_ff               <= '0;
         out_x_ff              <= '0;
         out_y_ff              <= '0;
         out_z_ff              <= '0;
         wr_addr_ff            <= '0;
         ctr_addr_ff           <= '0;
         zm_addr_ff            <= '0;
         in_done_ff            <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         in_x_ff     <= in_x_in;
         in_y_ff     <= in_y_in;
         in_z_ff     <= in_z_in;
         out_x_ff    <= out_x_in;
         out_y_ff    <= out_y_in;
         out_z_ff    <= out_z_in;
         wr_addr_ff  <= wr_addr_in;
         ctr_addr_ff <= ctr_addr_in;
         zm_addr_ff  <= zm_addr_in;
         in_done_ff  <= in_done_in;
      end
   end

endmodule

`default_nettype wire

[src/uvg_queue.sv]
// ----------------------------------------------------------------------------
// uvg_queue
// short fifo of classified transactions between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module uvg_queue
   import uvg_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  queue_entry_type       push_entry,
   input  wire logic             pop,
   output queue_entry_type       head_entry,
   output queue_status_type      status
);

   queue_entry_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;
   logic                   do_push, do_pop;

   always_comb begin
      status.count = count_ff;
      status.full  = (count_ff == (QPTR_BITS + 1)'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_ptr_in    = do_push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in    = do_pop ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in     = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QPTR_BITS + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QPTR_BITS + 1)'(1);
      end
      head_entry   = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[src/uvg_back.sv]
// ----------------------------------------------------------------------------
// uvg_back
// plane store access, neighbor differences and upwind selection
// ----------------------------------------------------------------------------
`default_nettype none

module uvg_back
   import uvg_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  cfg_type                     cfg,
   input  wire logic                   deq_valid,
   input  queue_entry_type             deq_entry,
   output logic                        deq_pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic signed [GRAD_BITS-1:0] rsp_grad_x,
   output logic signed [GRAD_BITS-1:0] rsp_grad_y,
   output logic signed [GRAD_BITS-1:0] rsp_grad_z,
   output logic                        rsp_last
);

   logic                 adv;
   logic [ADDR_BITS-1:0] w_off, xm_addr, xp_addr, ym_addr, yp_addr;
   logic [SAMPLE_BITS-1:0] rd_ctr, rd_zm, rd_xm, rd_xp, rd_ym, rd_yp;

   // stage 1: read data in the rams, side info here
   logic                          s1_valid_ff, s1_valid_in;
   axis_mode_type                 s1_mode_x_ff, s1_mode_y_ff, s1_mode_z_ff;
   logic signed [SAMPLE_BITS-1:0] s1_zf_ff;
   logic                          s1_last_ff;

   // stage 2: differences, clamped where upwinding applies
   logic                        s2_valid_ff;
   axis_mode_type               s2_mode_x_ff, s2_mode_y_ff, s2_mode_z_ff;
   logic                        s2_last_ff;
   logic signed [GRAD_BITS-1:0] s2_fx_ff, s2_bx_ff, s2_fy_ff, s2_by_ff, s2_fz_ff, s2_bz_ff;
   logic signed [GRAD_BITS-1:0] s2_fx_in, s2_bx_in, s2_fy_in, s2_by_in, s2_fz_in, s2_bz_in;

   // output register
   logic                        rsp_valid_ff;
   logic signed [GRAD_BITS-1:0] rsp_gx_ff, rsp_gy_ff, rsp_gz_ff;
   logic                        rsp_last_ff;

   function automatic logic signed [GRAD_BITS-1:0] diff(input logic [SAMPLE_BITS-1:0] a,
                                                        input logic [SAMPLE_BITS-1:0] b);
      return {a[SAMPLE_BITS-1], a} - {b[SAMPLE_BITS-1], b};
   endfunction

   function automatic logic signed [GRAD_BITS-1:0] clamp_fwd(input axis_mode_type mode,
                                                             input logic signed [GRAD_BITS-1:0] d,
                                                             input logic wind);
      if (mode == AXIS_UPWIND && (d[GRAD_BITS-1] == wind)) return '0;
      return d;
   endfunction

   function automatic logic signed [GRAD_BITS-1:0] clamp_back(input axis_mode_type mode,
                                                              input logic signed [GRAD_BITS-1:0] d,
                                                              input logic wind);
      if (mode == AXIS_UPWIND && (d[GRAD_BITS-1] != wind)) return '0;
      return d;
   endfunction

   function automatic logic signed [GRAD_BITS-1:0] resolve(input axis_mode_type mode,
                                                           input logic signed [GRAD_BITS-1:0] f,
                                                           input logic signed [GRAD_BITS-1:0] b,
                                                           input logic wind);
      logic signed [GRAD_BITS:0] f_ext;
      logic signed [GRAD_BITS:0] b_ext;
      logic signed [GRAD_BITS:0] mag_f;
      logic signed [GRAD_BITS:0] mag_b;
      f_ext = {f[GRAD_BITS-1], f};
      b_ext = {b[GRAD_BITS-1], b};
      mag_f = wind ? f_ext : -f_ext;
      mag_b = wind ? -b_ext : b_ext;
      case (mode)
         AXIS_ZERO:   return '0;
         AXIS_BACK:   return b;
         AXIS_FWD:    return f;
         AXIS_UPWIND: return (mag_f > mag_b) ? f : b;   // tie keeps backward
         default:     return '0;
      endcase
   endfunction

   // whole back end moves together, held only by a stalled result
   assign adv     = !rsp_valid_ff || rsp_ready;
   assign deq_pop = adv && deq_valid;

   always_comb begin
      w_off       = ADDR_BITS'(cfg.vol_width);
      xm_addr     = deq_entry.ctr_addr - ADDR_BITS'(1);
      xp_addr     = deq_entry.ctr_addr + ADDR_BITS'(1);
      ym_addr     = deq_entry.ctr_addr - w_off;
      yp_addr     = deq_entry.ctr_addr + w_off;
      s1_valid_in = deq_pop && deq_entry.emit;
   end

   uvg_ram u_ram_ctr (
      .clock     (clock),
      .wr_en     (deq_pop && deq_entry.wr_en),
      .wr_addr   (deq_entry.wr_addr),
      .wr_data   (deq_entry.sample),
      .rd_en     (adv),
      .rd_addr_a (deq_entry.ctr_addr),
      .rd_addr_b (deq_entry.zm_addr),
      .rd_data_a (rd_ctr),
      .rd_data_b (rd_zm)
   );

   uvg_ram u_ram_x (
      .clock     (clock),
      .wr_en     (deq_pop && deq_entry.wr_en),
      .wr_addr   (deq_entry.wr_addr),
      .wr_data   (deq_entry.sample),
      .rd_en     (adv),
      .rd_addr_a (xm_addr),
      .rd_addr_b (xp_addr),
      .rd_data_a (rd_xm),
      .rd_data_b (rd_xp)
   );

   uvg_ram u_ram_y (
      .clock     (clock),
      .wr_en     (deq_pop && deq_entry.wr_en),
      .wr_addr   (deq_entry.wr_addr),
      .wr_data   (deq_entry.sample),
      .rd_en     (adv),
      .rd_addr_a (ym_addr),
      .rd_addr_b (yp_addr),
      .rd_data_a (rd_ym),
      .rd_data_b (rd_yp)
   );

   always_comb begin
      s2_bx_in = clamp_back(s1_mode_x_ff, diff(rd_ctr, rd_xm), cfg.wind_direction);
      s2_fx_in = clamp_fwd(s1_mode_x_ff, diff(rd_xp, rd_ctr), cfg.wind_direction);
      s2_by_in = clamp_back(s1_mode_y_ff, diff(rd_ctr, rd_ym), cfg.wind_direction);
      s2_fy_in = clamp_fwd(s1_mode_y_ff, diff(rd_yp, rd_ctr), cfg.wind_direction);
      s2_bz_in = clamp_back(s1_mode_z_ff, diff(rd_ctr, rd_zm), cfg.wind_direction);
      s2_fz_in = clamp_fwd(s1_mode_z_ff, diff(s1_zf_ff, rd_ctr), cfg.wind_direction);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_mode_x_ff <= deq_entry.mode_x;
         s1_mode_y_ff <= deq_entry.mode_y;
         s1_mode_z_ff <= deq_entry.mode_z;
         s1_zf_ff     <= deq_entry.sample;
         s1_last_ff   <= deq_entry.last;
         s2_mode_x_ff <= s1_mode_x_ff;
         s2_mode_y_ff <= s1_mode_y_ff;
         s2_mode_z_ff <= s1_mode_z_ff;
         s2_last_ff   <= s1_last_ff;
         s2_fx_ff     <= s2_fx_in;
         s2_bx_ff     <= s2_bx_in;
         s2_fy_ff     <= s2_fy_in;
         s2_by_ff     <= s2_by_in;
         s2_fz_ff     <= s2_fz_in;
         s2_bz_ff     <= s2_bz_in;
         rsp_gx_ff    <= resolve(s2_mode_x_ff, s2_fx_ff, s2_bx_ff, cfg.wind_direction);
         rsp_gy_ff    <= resolve(s2_mode_y_ff, s2_fy_ff, s2_by_ff, cfg.wind_direction);
         rsp_gz_ff    <= resolve(s2_mode_z_ff, s2_fz_ff, s2_bz_ff, cfg.wind_direction);
         rsp_last_ff  <= s2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_grad_x = rsp_gx_ff;
   assign rsp_grad_y = rsp_gy_ff;
   assign rsp_grad_z = rsp_gz_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

[src/upwind_volume_gradient_unit.sv]
// ----------------------------------------------------------------------------
// upwind_volume_gradient_unit
// streaming 3-d upwind gradient over a raster-ordered voxel volume
// ----------------------------------------------------------------------------
// Samples are pushed in raster order (x fastest, then y, then z) and one
// gradient comes out per voxel, in the same order, once its forward z
// neighbor has arrived, so results trail the pushes by one plane
// (vol_width*vol_height voxels); after the last push, flush transactions drain
// the final plane, one voxel per flush. The unit takes one transaction per
// clock cycle while results are taken: the front classifies each transaction
// and computes neighbor addresses, a four-entry queue decouples it from the
// back, and the back fetches the center and its five stored neighbors together
// from three identical copies of the two-plane store (8192 x 16, two read
// ports each), taking the forward z neighbor from the incoming sample, then
// spends one stage on differences and one on the upwind choice. A stalled
// result holds the whole back end, and input stalls once the queue fills.
// There is no clearing pass after reset. The user must write registers only
// while the unit is idle; the unit itself does not enforce this, and any
// write abandons a partial volume.
// ----------------------------------------------------------------------------
`default_nettype none

module upwind_volume_gradient_unit
   import uvg_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,

   // register write channel
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [CSR_ADDR_BITS-1:0]      csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0]      csr_wdata,

   // sample and flush transactions
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_cmd,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample,

   // gradient results
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [GRAD_BITS-1:0]        rsp_grad_x,
   output logic signed [GRAD_BITS-1:0]        rsp_grad_y,
   output logic signed [GRAD_BITS-1:0]        rsp_grad_z,
   output logic                               rsp_last
);

   cfg_type          cfg;
   logic             in_done;
   logic             enq_valid;
   queue_entry_type  enq_entry;
   queue_entry_type  head_entry;
   queue_status_type q_status;
   logic             deq_pop;

   // front: registers, raster counters, classification of each transaction
   uvg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_cmd    (req_cmd),
      .req_sample (req_sample),
      .queue_full (q_status.full),
      .enq_valid  (enq_valid),
      .enq_entry  (enq_entry),
      .cfg        (cfg),
      .in_done    (in_done)
   );

   // decoupling queue: ignored pushes and early flushes never enter
   uvg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (enq_valid),
      .push_entry (enq_entry),
      .pop        (deq_pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   // back: store write, neighbor fetch, differences, upwind resolve
   uvg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .deq_valid  (!q_status.empty),
      .deq_entry  (head_entry),
      .deq_pop    (deq_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_grad_x (rsp_grad_x),
      .rsp_grad_y (rsp_grad_y),
      .rsp_grad_z (rsp_grad_z),
      .rsp_last   (rsp_last)
   );

   // queue occupancy stays within its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= (QPTR_BITS + 1)'(QUEUE_DEPTH))
      else $error("queue occupancy beyond depth");

   // the front never offers a transaction the queue cannot hold
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      enq_valid |-> !q_status.full)
      else $error("transaction enqueued into full queue");

   // classifying the final voxel closes the volume on the input side
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      enq_valid && enq_entry.emit && enq_entry.last |=> !in_done)
      else $error("volume still open after final voxel");

   // a register write abandons the current volume
   a_csr_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !in_done)
      else $error("volume still open after register write");

endmodule

`default_nettype wire
